// ----- design/clt_pkg.sv -----
`default_nettype none
// Package for the command line tokenizer: scan modes, token kinds, result record,
// the command word table and character helpers. No dependencies.
package clt_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUM
    } mode_t;

    localparam logic [4:0] KIND_IDENT   = 5'd0;
    localparam logic [4:0] KIND_TEXT    = 5'd1;
    localparam logic [4:0] KIND_KEYWORD = 5'd2;
    localparam logic [4:0] KIND_NUMBER  = 5'd3;
    localparam logic [4:0] KIND_NONE    = 5'd0;
    localparam logic [4:0] KIND_PLUS    = 5'd4;
    localparam logic [4:0] KIND_LPAREN  = 5'd5;
    localparam logic [4:0] KIND_RPAREN  = 5'd6;
    localparam logic [4:0] KIND_DQUOTE  = 5'd7;
    localparam logic [4:0] KIND_COMMA   = 5'd8;
    localparam logic [4:0] KIND_SEMI    = 5'd9;
    localparam logic [4:0] KIND_LBRACK  = 5'd10;
    localparam logic [4:0] KIND_RBRACK  = 5'd11;
    localparam logic [4:0] KIND_LBRACE  = 5'd12;
    localparam logic [4:0] KIND_RBRACE  = 5'd13;
    localparam logic [4:0] KIND_QMARK   = 5'd14;
    localparam logic [4:0] KIND_DOT     = 5'd15;
    localparam logic [4:0] KIND_PIPE    = 5'd16;
    localparam logic [4:0] KIND_SQUOTE  = 5'd17;
    localparam logic [4:0] KIND_EQUAL   = 5'd18;
    localparam logic [4:0] KIND_END     = 5'd19;
    localparam logic [4:0] KIND_OTHER   = 5'd20;

    localparam int WORD_SLOTS = 16;
    localparam int WORD_CHARS = 32;

    // Words are stored right-justified, as string literals pack.
    localparam logic [WORD_CHARS*8-1:0] KW_TEXT [WORD_SLOTS] = '{
        {"CREAR_", "CLIENTE"}, {"ENVIAR_", "MENSAJE"}, "ESTRESAR",
        {"OBTENER_", "MENSAJES"}, "LISTA", "LIMPIAR", {"BUSCAR_", "CLIENTE"},
        '0, '0, '0, '0, '0, '0, '0, '0, '0
    };
    localparam logic [5:0] KW_LEN [WORD_SLOTS] = '{
        6'd13, 6'd14, 6'd8, 6'd16, 6'd5, 6'd7, 6'd14,
        6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0
    };

    typedef struct packed {
        logic [4:0]  kind;
        logic [2:0]  kw_index;
        logic [63:0] number;
        logic [7:0]  length;
        logic [7:0]  char_code;
        logic [15:0] line;
        logic        last;
    } token_t;

    function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [4:0] pos);
        logic [WORD_CHARS*8-1:0] w;
        int n;
        int idx;
        w = KW_TEXT[k];
        n = int'(KW_LEN[k]);
        idx = n - 1 - int'(pos);
        if (int'(pos) < n) begin
            kw_char = w[idx*8 +: 8];
        end else begin
            kw_char = 8'd0;
        end
    endfunction

    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        unique case (c)
            "+":     punct_kind = KIND_PLUS;
            "(":     punct_kind = KIND_LPAREN;
            ")":     punct_kind = KIND_RPAREN;
            "\"":    punct_kind = KIND_DQUOTE;
            ",":     punct_kind = KIND_COMMA;
            ";":     punct_kind = KIND_SEMI;
            "[":     punct_kind = KIND_LBRACK;
            "]":     punct_kind = KIND_RBRACK;
            "{":     punct_kind = KIND_LBRACE;
            "}":     punct_kind = KIND_RBRACE;
            "?":     punct_kind = KIND_QMARK;
            ".":     punct_kind = KIND_DOT;
            "|":     punct_kind = KIND_PIPE;
            "'":     punct_kind = KIND_SQUOTE;
            "=":     punct_kind = KIND_EQUAL;
            default: punct_kind = KIND_NONE;
        endcase
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= "0" && c <= "9");
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        to_upper = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

endpackage
`default_nettype wire

// ----- design/command_line_tokenizer.sv -----
`default_nettype none
// Top level of the command line tokenizer: input register, scanner state,
// single-pass token logic and a four-entry result queue. Depends on clt_pkg.

// The block takes one character per request and gives tokens on the result channel.
// A request is registered, then decoded against the scanner state, and the zero, one
// or two tokens it causes are written into a four-entry result queue. A new request
// can be taken every cycle while the queue has room for two tokens, so the sustained
// rate is one character per clock while the result side drains the queue; a character
// that ends a pending identifier or number and is itself a token adds a second token,
// which the queue absorbs. The first token of a request is presented once the
// registered request has fired and its tokens are written into the queue.
module command_line_tokenizer #(
    parameter int KEYWORD_COUNT      = 7,
    parameter int KEYWORD_MAX_LENGTH = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [7:0]  s_character,
    input  wire         s_end_of_input,
    input  wire         s_keyword_check,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [4:0]  m_token_kind,
    output logic [2:0]  m_keyword_index,
    output logic [63:0] m_number_value,
    output logic [7:0]  m_token_length,
    output logic [7:0]  m_token_char,
    output logic [15:0] m_line_number,
    output logic        m_last_of_run
);
    import clt_pkg::*;

    localparam int QUEUE_DEPTH = 4;

    logic                     in_valid_reg;
    logic [7:0]               in_char_reg;
    logic                     in_eoi_reg;
    logic                     in_check_reg;

    mode_t                    mode_reg, mode_next;
    logic [KEYWORD_COUNT-1:0] match_reg, match_next;
    logic [7:0]               length_reg, length_next;
    logic [63:0]              acc_reg, acc_next;
    logic [15:0]              line_reg, line_next;

    token_t                   queue_reg [QUEUE_DEPTH];
    logic [1:0]               wr_ptr_reg;
    logic [1:0]               rd_ptr_reg;
    logic [2:0]               count_reg;

    logic                     fire;
    logic                     pop;
    logic                     c_letter, c_digit, c_ident, c_space, c_newline;
    logic [7:0]               c_upper;
    logic [4:0]               c_punct;
    logic                     pending;
    logic                     keep_going;
    logic [67:0]              acc_prod;
    logic [KEYWORD_COUNT-1:0] match_step_out;
    logic                     r0_valid, r1_valid;
    token_t                   r0, r1;

    function automatic logic [KEYWORD_COUNT-1:0] match_step(
        input logic [KEYWORD_COUNT-1:0] m,
        input logic [7:0]               pos,
        input logic [7:0]               up
    );
        logic [KEYWORD_COUNT-1:0] res;
        res = m;
        for (int k = 0; k < KEYWORD_COUNT; k++) begin
            if (int'(pos) >= KEYWORD_MAX_LENGTH || pos >= {2'b00, KW_LEN[k]} ||
                kw_char(4'(k), pos[4:0]) != up) begin
                res[k] = 1'b0;
            end
        end
        match_step = res;
    endfunction

    assign fire    = in_valid_reg && (count_reg <= 3'd2);
    assign s_ready = !in_valid_reg || fire;
    assign pop     = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_char_reg  <= s_character;
            in_eoi_reg   <= s_end_of_input;
            in_check_reg <= s_keyword_check;
        end
    end

    always_comb begin
        c_letter   = is_letter(in_char_reg);
        c_digit    = is_digit(in_char_reg);
        c_ident    = c_letter || c_digit || in_char_reg == "_" || in_char_reg == "-";
        c_newline  = in_char_reg == "\n";
        c_space    = in_char_reg == " " || in_char_reg == "\t" || c_newline;
        c_upper    = to_upper(in_char_reg);
        c_punct    = punct_kind(in_char_reg);
        pending    = mode_reg == MODE_IDENT || mode_reg == MODE_NUM;
        keep_going = !in_eoi_reg && ((mode_reg == MODE_IDENT && c_ident) ||
                                     (mode_reg == MODE_NUM && c_digit));
        acc_prod   = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) +
                     68'(in_char_reg - "0");
        match_step_out = match_step(
            (mode_reg == MODE_IDENT) ? match_reg : {KEYWORD_COUNT{1'b1}},
            (mode_reg == MODE_IDENT) ? length_reg : 8'd0, c_upper);
    end

    // Next scanner state.
    always_comb begin
        mode_next   = mode_reg;
        match_next  = match_reg;
        length_next = length_reg;
        acc_next    = acc_reg;
        line_next   = line_reg;
        if (fire) begin
            if (in_eoi_reg) begin
                mode_next = MODE_IDLE;
            end else if (keep_going) begin
                if (length_reg != 8'hFF) begin
                    length_next = length_reg + 8'd1;
                end
                if (mode_reg == MODE_IDENT) begin
                    match_next = match_step_out;
                end else begin
                    acc_next = (|acc_prod[67:64]) ? '1 : acc_prod[63:0];
                end
            end else begin
                mode_next = MODE_IDLE;
                if (c_space) begin
                    if (c_newline && line_reg != 16'hFFFF) begin
                        line_next = line_reg + 16'd1;
                    end
                end else if (c_letter) begin
                    mode_next   = MODE_IDENT;
                    length_next = 8'd1;
                    match_next  = match_step_out;
                end else if (c_digit) begin
                    mode_next   = MODE_NUM;
                    length_next = 8'd1;
                    acc_next    = 64'(in_char_reg - "0");
                end
            end
        end
    end

    // Tokens caused by the current request.
    always_comb begin
        r0           = '0;
        r1           = '0;
        r0.line      = line_reg;
        r1.line      = line_reg;
        r0.length    = length_reg;
        r0_valid     = fire && pending && !keep_going;
        r1_valid     = 1'b0;
        if (mode_reg == MODE_IDENT) begin
            r0.kind = in_check_reg ? KIND_IDENT : KIND_TEXT;
            if (in_check_reg) begin
                for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
                    if (match_reg[k] && length_reg == {2'b00, KW_LEN[k]}) begin
                        r0.kind     = KIND_KEYWORD;
                        r0.kw_index = 3'(k);
                    end
                end
            end
        end else begin
            r0.kind   = KIND_NUMBER;
            r0.number = acc_reg;
        end
        if (fire && in_eoi_reg) begin
            r1_valid = 1'b1;
            r1.kind  = KIND_END;
        end else if (fire && !keep_going && !c_space && !c_letter && !c_digit) begin
            r1_valid     = 1'b1;
            r1.kind      = (c_punct != KIND_NONE) ? c_punct : KIND_OTHER;
            r1.length    = 8'd1;
            r1.char_code = in_char_reg;
        end
        r0.last = !r1_valid;
        r1.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            match_reg  <= {KEYWORD_COUNT{1'b1}};
            length_reg <= 8'd0;
            acc_reg    <= 64'd0;
            line_reg   <= 16'd1;
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            mode_reg   <= mode_next;
            match_reg  <= match_next;
            length_reg <= length_next;
            acc_reg    <= acc_next;
            line_reg   <= line_next;
            wr_ptr_reg <= wr_ptr_reg + {1'b0, r0_valid} + {1'b0, r1_valid};
            rd_ptr_reg <= rd_ptr_reg + {1'b0, pop};
            count_reg  <= count_reg + {2'b00, r0_valid} + {2'b00, r1_valid} - {2'b00, pop};
        end
        if (r0_valid) begin
            queue_reg[wr_ptr_reg] <= r0;
        end
        if (r1_valid) begin
            queue_reg[r0_valid ? wr_ptr_reg + 2'd1 : wr_ptr_reg] <= r1;
        end
    end

    assign m_valid         = count_reg != 3'd0;
    assign m_token_kind    = queue_reg[rd_ptr_reg].kind;
    assign m_keyword_index = queue_reg[rd_ptr_reg].kw_index;
    assign m_number_value  = queue_reg[rd_ptr_reg].number;
    assign m_token_length  = queue_reg[rd_ptr_reg].length;
    assign m_token_char    = queue_reg[rd_ptr_reg].char_code;
    assign m_line_number   = queue_reg[rd_ptr_reg].line;
    assign m_last_of_run   = queue_reg[rd_ptr_reg].last;

`ifndef SYNTH
    // The result queue never holds more tokens than it has entries.
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'(QUEUE_DEPTH))
        else $error("result queue overflow");

    // Line numbering starts at one and never wraps to zero.
    a_line_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        line_reg != 16'd0)
        else $error("line counter reached zero");

    // An end of input request always leaves the scanner idle.
    a_eoi_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_eoi_reg |=> mode_reg == MODE_IDLE)
        else $error("scanner not idle after end of input");

    // A token being collected always has at least one character.
    a_pending_len: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg != MODE_IDLE |-> length_reg != 8'd0)
        else $error("pending token with zero length");
`endif

endmodule
`default_nettype wire
